/* src/status_led_pattern_serializer_macros.svh */
// assertion macros for the status led pattern serializer
// used by the queue front end and the sequencer back end
`ifndef STATUS_LED_PATTERN_SERIALIZER_MACROS_SVH
`define STATUS_LED_PATTERN_SERIALIZER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SLPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define SLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/slps_pkg.sv */
// shared types, codes and pattern tables of the status led pattern serializer
// no dependencies
`timescale 1ns / 1ps
package slps_pkg;

  // command codes on the input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MODE  = 2'd1;
  localparam logic [1:0] CMD_COLOR = 2'd2;

  // status modes
  localparam logic [2:0] MODE_INIT       = 3'd0;
  localparam logic [2:0] MODE_CONNECTING = 3'd1;
  localparam logic [2:0] MODE_OK         = 3'd2;
  localparam logic [2:0] MODE_ACTIVE_TX  = 3'd3;
  localparam logic [2:0] MODE_WATERING   = 3'd4;
  localparam logic [2:0] MODE_ERROR      = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_BIT_PERIOD = 3'd2;
  localparam logic [2:0] REG_LATCH_GAP  = 3'd3;
  localparam logic [2:0] REG_TICKS_MS   = 3'd4;

  // configuration reset values
  localparam logic [7:0]  ZERO_HIGH_RST  = 8'd8;
  localparam logic [7:0]  ONE_HIGH_RST   = 8'd16;
  localparam logic [7:0]  BIT_PERIOD_RST = 8'd25;
  localparam logic [15:0] LATCH_GAP_RST  = 16'd1200;
  localparam logic [15:0] TICKS_MS_RST   = 16'd20000;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [4:0]  PIXEL_BITS  = 5'd23 + 5'd1;

  // classified word kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_COLOR = 2'd2,
    KIND_NONE  = 2'd3
  } item_kind_e;

  // one classified word in the queue, pixel in grb order
  typedef struct packed {
    item_kind_e  kind;
    logic [2:0]  mode;
    logic [23:0] pixel;
  } slps_item_t;

  // does the mode play a second segment
  function automatic logic two_seg(input logic [2:0] mode);
    logic r;
    case (mode)
      MODE_INIT, MODE_CONNECTING, MODE_ACTIVE_TX, MODE_ERROR: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // hold time of a segment in ms
  function automatic logic [9:0] seg_ms(input logic [2:0] mode, input logic seg);
    logic [9:0] r;
    case (mode)
      MODE_INIT:       r = 10'd500;
      MODE_CONNECTING: r = 10'd300;
      MODE_OK:         r = seg ? 10'd0 : 10'd1000;
      MODE_ACTIVE_TX:  r = seg ? 10'd500 : 10'd100;
      MODE_WATERING:   r = seg ? 10'd0 : 10'd200;
      MODE_ERROR:      r = 10'd200;
      default:         r = 10'd0;
    endcase
    return r;
  endfunction

  // segment color packed as green, red, blue
  function automatic logic [23:0] seg_color(input logic [2:0] mode, input logic seg);
    logic [23:0] r;
    case (mode)
      MODE_INIT:       r = seg ? 24'h000000 : {8'd20, 8'd20, 8'd20};
      MODE_CONNECTING: r = seg ? 24'h000000 : {8'd20, 8'd30, 8'd0};
      MODE_OK:         r = seg ? 24'h000000 : {8'd30, 8'd0, 8'd0};
      MODE_ACTIVE_TX:  r = seg ? {8'd30, 8'd0, 8'd0} : {8'd30, 8'd0, 8'd30};
      MODE_WATERING:   r = seg ? 24'h000000 : {8'd0, 8'd0, 8'd40};
      MODE_ERROR:      r = seg ? 24'h000000 : {8'd0, 8'd40, 8'd0};
      default:         r = 24'h000000;
    endcase
    return r;
  endfunction

endpackage

/* src/slps_front.sv */
// front end: accepts input words, classifies them and queues them
// depends on slps_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "status_led_pattern_serializer_macros.svh"
module slps_front #(
  parameter int unsigned DEPTH = slps_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [2:0]          mode_value_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                head_valid_o,
  output slps_pkg::slps_item_t head_o,
  input  logic                pop_i
);
  import slps_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  slps_item_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  slps_item_t            item;
  logic                  push, pop;

  // classify the incoming word
  always_comb begin
    item.mode  = mode_value_i;
    item.pixel = {green_i, red_i, blue_i};
    case (command_i)
      CMD_TICK:  item.kind = KIND_TICK;
      CMD_MODE:  item.kind = (mode_value_i <= MODE_ERROR) ? KIND_MODE : KIND_NONE;
      CMD_COLOR: item.kind = KIND_COLOR;
      default:   item.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != CntW'(DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SLPS_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0, "pop from empty queue")
  `SLPS_ASSERT_NEXT(a_fill_up, clk_i, rst_ni, push && !pop, cnt_q == CntW'($past(cnt_q) + 1'b1), "fill count did not rise")
  `SLPS_ASSERT_NEXT(a_fill_down, clk_i, rst_ni, pop && !push, cnt_q == CntW'($past(cnt_q) - 1'b1), "fill count did not fall")

endmodule

/* src/slps_back.sv */
// back end: pattern sequencer, bit serializer, config registers, output register
// depends on slps_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "status_led_pattern_serializer_macros.svh"
module slps_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [slps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                head_valid_i,
  input  slps_pkg::slps_item_t                head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                led_line_o,
  output logic                                serializer_busy_o,
  output logic [2:0]                          shown_mode_o,
  output logic                                segment_index_o
);
  import slps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BITS  = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  // configuration
  logic [7:0]  zero_high_q, one_high_q, period_q;
  logic [15:0] gap_q, tpm_q;

  // sequencer and serializer state
  logic [2:0]  pend_mode_q, pend_mode_d, active_q, active_d;
  logic        seg_q, seg_d;
  logic [15:0] pre_q, pre_d;
  logic [9:0]  rem_q, rem_d;
  logic [23:0] pix_q, pix_d, shift_q, shift_d;
  logic        pvalid_q, pvalid_d;
  logic [4:0]  bits_q, bits_d;
  logic [7:0]  bt_q, bt_d;
  logic [15:0] lt_q, lt_d;
  phase_e      phase_q, phase_d;
  logic        line_q, line_d;

  // intermediates
  logic [15:0] tpm, pre_inc, lt_inc;
  logic [9:0]  rem_dec;
  logic [7:0]  high, bt_inc;
  logic        start_pat, next_seg, adv;

  logic        out_valid_q;

  assign adv   = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = adv;
  assign tpm   = (tpm_q == '0) ? 16'd1 : tpm_q;

  // one step of the model for the word at the queue head
  always_comb begin
    pend_mode_d = pend_mode_q;
    active_d    = active_q;
    seg_d       = seg_q;
    pre_d       = pre_q;
    rem_d       = rem_q;
    pix_d       = pix_q;
    pvalid_d    = pvalid_q;
    shift_d     = shift_q;
    bits_d      = bits_q;
    bt_d        = bt_q;
    lt_d        = lt_q;
    phase_d     = phase_q;
    line_d      = line_q;
    pre_inc     = pre_q + 16'd1;
    rem_dec     = rem_q - 10'd1;
    start_pat   = 1'b0;
    next_seg    = 1'b0;
    high        = '0;
    bt_inc      = '0;
    lt_inc      = '0;
    case (head_i.kind)
      KIND_TICK: begin
        // pattern timer
        if (rem_q == '0) begin
          start_pat = 1'b1;
        end else begin
          pre_d = pre_inc;
          if (pre_inc >= tpm || pre_inc == '0) begin
            pre_d = '0;
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              if (!seg_q && two_seg(active_q)) begin
                next_seg = 1'b1;
                seg_d    = 1'b1;
                if (active_q == MODE_ACTIVE_TX) begin
                  pend_mode_d = MODE_OK;
                end
              end else begin
                start_pat = 1'b1;
              end
            end
          end
        end
        if (start_pat) begin
          active_d = pend_mode_q;
          seg_d    = 1'b0;
        end
        if (start_pat || next_seg) begin
          rem_d    = seg_ms(active_d, seg_d);
          pre_d    = '0;
          pix_d    = seg_color(active_d, seg_d);
          pvalid_d = 1'b1;
        end
        // serializer: load a waiting pixel when idle
        if (phase_q != PH_BITS && phase_q != PH_LATCH) begin
          phase_d = PH_IDLE;
          if (pvalid_d) begin
            shift_d  = pix_d;
            pvalid_d = 1'b0;
            bits_d   = PIXEL_BITS;
            bt_d     = '0;
            phase_d  = PH_BITS;
          end
        end
        // serializer: bit and latch timing
        if (phase_d == PH_BITS) begin
          high   = shift_d[23] ? one_high_q : zero_high_q;
          line_d = (bt_d < high);
          bt_inc = bt_d + 8'd1;
          bt_d   = bt_inc;
          if (bt_inc >= period_q || bt_inc == '0) begin
            bt_d    = '0;
            shift_d = {shift_d[22:0], 1'b0};
            bits_d  = bits_d - 5'd1;
            if (bits_d == '0) begin
              phase_d = PH_LATCH;
              lt_d    = '0;
            end
          end
        end else if (phase_d == PH_LATCH) begin
          line_d = 1'b0;
          lt_inc = lt_q + 16'd1;
          lt_d   = lt_inc;
          if (lt_inc >= gap_q || lt_inc == '0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          line_d = 1'b0;
        end
      end
      KIND_MODE: begin
        pend_mode_d = head_i.mode;
      end
      KIND_COLOR: begin
        pix_d    = head_i.pixel;
        pvalid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= ZERO_HIGH_RST;
      one_high_q  <= ONE_HIGH_RST;
      period_q    <= BIT_PERIOD_RST;
      gap_q       <= LATCH_GAP_RST;
      tpm_q       <= TICKS_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ZERO_HIGH:  zero_high_q <= cfg_data_i[7:0];
        REG_ONE_HIGH:   one_high_q  <= cfg_data_i[7:0];
        REG_BIT_PERIOD: period_q    <= cfg_data_i[7:0];
        REG_LATCH_GAP:  gap_q       <= cfg_data_i;
        REG_TICKS_MS:   tpm_q       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer and serializer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_mode_q <= MODE_INIT;
      active_q    <= MODE_INIT;
      seg_q       <= 1'b0;
      pre_q       <= '0;
      rem_q       <= '0;
      pix_q       <= '0;
      pvalid_q    <= 1'b0;
      shift_q     <= '0;
      bits_q      <= '0;
      bt_q        <= '0;
      lt_q        <= '0;
      phase_q     <= PH_IDLE;
      line_q      <= 1'b0;
    end else if (adv) begin
      pend_mode_q <= pend_mode_d;
      active_q    <= active_d;
      seg_q       <= seg_d;
      pre_q       <= pre_d;
      rem_q       <= rem_d;
      pix_q       <= pix_d;
      pvalid_q    <= pvalid_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      bt_q        <= bt_d;
      lt_q        <= lt_d;
      phase_q     <= phase_d;
      line_q      <= line_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      led_line_o        <= line_d;
      serializer_busy_o <= (phase_d == PH_BITS) || (phase_d == PH_LATCH);
      shown_mode_o      <= active_d;
      segment_index_o   <= seg_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SLPS_ASSERT_IMPL(a_idle_line_low, clk_i, rst_ni, phase_q == PH_IDLE, !line_q, "line high while idle")
  `SLPS_ASSERT_IMPL(a_bits_left, clk_i, rst_ni, phase_q == PH_BITS, bits_q != '0, "bit phase with no bits left")
  `SLPS_ASSERT_IMPL(a_seg_two, clk_i, rst_ni, seg_q, two_seg(active_q), "second segment in single segment mode")

endmodule

/* src/status_led_pattern_serializer.sv */
// a word accepted into the queue is worked by the back end at the queue head; its result word is then registered
// throughput: one word per cycle while out_ready_i does not stall the output register
// a two-entry queue parts the input from the back end, an output register holds the result
// reset: asynchronous active low; config registers take their defaults, the pattern
// starts on the first tick word and the line state is low; the result fields have no reset
`timescale 1ns / 1ps
module status_led_pattern_serializer #(
  parameter int unsigned QUEUE_DEPTH = slps_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [2:0]                      mode_value_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            led_line_o,
  output logic                            serializer_busy_o,
  output logic [2:0]                      shown_mode_o,
  output logic                            segment_index_o
);
  import slps_pkg::*;

  slps_item_t head;
  logic       head_valid, pop;

  // classify and queue
  slps_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .mode_value_i,
    .red_i,
    .green_i,
    .blue_i,
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  // sequence and serialize
  slps_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .led_line_o,
    .serializer_busy_o,
    .shown_mode_o,
    .segment_index_o
  );

endmodule

/* bench/status_led_pattern_serializer_tb.sv */
// testbench for the status led pattern serializer: directed and random words
// checked against a word-by-word predictor kept in a small scoreboard class
// depends on slps_pkg and status_led_pattern_serializer
`timescale 1ns / 1ps
module status_led_pattern_serializer_tb;
  import slps_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] CMD_RSVD     = 2'd3;
  localparam logic [2:0] MODE_RSVD_LO = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;
  localparam int unsigned MAX_PRINTED = 20;

  // predicted sequencer and serializer state plus the queue of expected result words
  class led_pattern_scoreboard;
    typedef enum logic [1:0] {
      SER_IDLE  = 2'd0,
      SER_BITS  = 2'd1,
      SER_LATCH = 2'd2
    } ser_phase_e;

    typedef struct packed {
      logic       line;
      logic       busy;
      logic [2:0] mode;
      logic       seg;
    } led_word_t;

    logic [7:0]  zero_hi, one_hi, bit_len;
    logic [15:0] gap_len, ms_ticks;
    logic [2:0]  next_mode, play_mode;
    logic        seg;
    logic [15:0] prescale;
    logic [9:0]  ms_left;
    logic [23:0] held_pixel;
    logic        held_valid;
    logic [23:0] shift;
    logic [4:0]  bits_left;
    logic [7:0]  bit_tmr;
    logic [15:0] gap_tmr;
    ser_phase_e  phase;
    logic        line;
    led_word_t   expected_q[$];
    int unsigned errors, checked;
    logic [5:0]  modes_seen;

    function new();
      zero_hi    = ZERO_HIGH_RST;
      one_hi     = ONE_HIGH_RST;
      bit_len    = BIT_PERIOD_RST;
      gap_len    = LATCH_GAP_RST;
      ms_ticks   = TICKS_MS_RST;
      next_mode  = MODE_INIT;
      play_mode  = MODE_INIT;
      seg        = 1'b0;
      prescale   = '0;
      ms_left    = '0;
      held_pixel = '0;
      held_valid = 1'b0;
      shift      = '0;
      bits_left  = '0;
      bit_tmr    = '0;
      gap_tmr    = '0;
      phase      = SER_IDLE;
      line       = 1'b0;
      errors     = 0;
      checked    = 0;
      modes_seen = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ZERO_HIGH:  zero_hi  = data[7:0];
        REG_ONE_HIGH:   one_hi   = data[7:0];
        REG_BIT_PERIOD: bit_len  = data[7:0];
        REG_LATCH_GAP:  gap_len  = data;
        REG_TICKS_MS:   ms_ticks = data;
        default: ;
      endcase
    endfunction

    // hold time and grb color of one segment; a second segment with no hold means none
    function void segment_of(input logic [2:0] m, input logic s,
                             output logic [9:0] hold, output logic [23:0] grb);
      logic [7:0] r, g, b;
      r = '0;
      g = '0;
      b = '0;
      hold = '0;
      case (m)
        MODE_INIT: begin
          hold = 10'd500;
          if (!s) {r, g, b} = {8'd20, 8'd20, 8'd20};
        end
        MODE_CONNECTING: begin
          hold = 10'd300;
          if (!s) {r, g, b} = {8'd30, 8'd20, 8'd0};
        end
        MODE_OK: begin
          if (!s) begin
            hold = 10'd1000;
            g = 8'd30;
          end
        end
        MODE_ACTIVE_TX: begin
          g = 8'd30;
          if (!s) begin
            hold = 10'd100;
            b = 8'd30;
          end else begin
            hold = 10'd500;
          end
        end
        MODE_WATERING: begin
          if (!s) begin
            hold = 10'd200;
            b = 8'd40;
          end
        end
        MODE_ERROR: begin
          hold = 10'd200;
          if (!s) r = 8'd40;
        end
        default: ;
      endcase
      grb = {g, r, b};
    endfunction

    function void load_segment();
      logic [9:0]  hold;
      logic [23:0] grb;
      segment_of(play_mode, seg, hold, grb);
      ms_left    = hold;
      prescale   = '0;
      held_pixel = grb;
      held_valid = 1'b1;
    endfunction

    function void start_pattern();
      play_mode = next_mode;
      seg = 1'b0;
      modes_seen[play_mode] = 1'b1;
      load_segment();
    endfunction

    // millisecond timer and segment sequencing
    function void advance_pattern();
      logic [15:0] per_ms;
      logic [9:0]  hold;
      logic [23:0] grb;
      per_ms = (ms_ticks == '0) ? 16'd1 : ms_ticks;
      if (ms_left == '0) begin
        start_pattern();
        return;
      end
      prescale = prescale + 16'd1;
      if (prescale >= per_ms || prescale == '0) begin
        prescale = '0;
        ms_left  = ms_left - 10'd1;
        if (ms_left == '0) begin
          segment_of(play_mode, 1'b1, hold, grb);
          if (!seg && hold != '0) begin
            seg = 1'b1;
            if (play_mode == MODE_ACTIVE_TX) next_mode = MODE_OK;
            load_segment();
          end else begin
            start_pattern();
          end
        end
      end
    endfunction

    // bit timing, msb first, then the low latch gap
    function void advance_serializer();
      logic [7:0] high;
      if (phase == SER_IDLE && held_valid) begin
        shift      = held_pixel;
        held_valid = 1'b0;
        bits_left  = 5'd24;
        bit_tmr    = '0;
        phase      = SER_BITS;
      end
      case (phase)
        SER_BITS: begin
          high = shift[23] ? one_hi : zero_hi;
          line = (bit_tmr < high);
          bit_tmr = bit_tmr + 8'd1;
          if (bit_tmr >= bit_len || bit_tmr == '0) begin
            bit_tmr   = '0;
            shift     = shift << 1;
            bits_left = bits_left - 5'd1;
            if (bits_left == '0) begin
              phase   = SER_LATCH;
              gap_tmr = '0;
            end
          end
        end
        SER_LATCH: begin
          line = 1'b0;
          gap_tmr = gap_tmr + 16'd1;
          if (gap_tmr >= gap_len || gap_tmr == '0) phase = SER_IDLE;
        end
        default: line = 1'b0;
      endcase
    endfunction

    // apply one accepted input word and queue the result word it causes
    function void note_word(logic [1:0] cmd, logic [2:0] mode,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      led_word_t w;
      case (cmd)
        CMD_TICK: begin
          advance_pattern();
          advance_serializer();
        end
        CMD_MODE: if (mode <= MODE_ERROR) next_mode = mode;
        CMD_COLOR: begin
          held_pixel = {g, r, b};
          held_valid = 1'b1;
        end
        default: ;
      endcase
      w.line = line;
      w.busy = (phase != SER_IDLE);
      w.mode = play_mode;
      w.seg  = seg;
      expected_q.push_back(w);
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // compare one result word with the oldest expectation
    task check_word(logic got_line, logic got_busy, logic [2:0] got_mode, logic got_seg);
      led_word_t want;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got_line !== want.line)
        report($sformatf("word %0d led_line %b, expected %b", checked, got_line, want.line));
      if (got_busy !== want.busy)
        report($sformatf("word %0d serializer_busy %b, expected %b",
                         checked, got_busy, want.busy));
      if (got_mode !== want.mode)
        report($sformatf("word %0d shown_mode %0d, expected %0d",
                         checked, got_mode, want.mode));
      if (got_seg !== want.seg)
        report($sformatf("word %0d segment_index %b, expected %b", checked, got_seg, want.seg));
    endtask
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = '0;
  logic [15:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i    = '0;
  logic [2:0]  mode_value_i = '0;
  logic [7:0]  red_i        = '0;
  logic [7:0]  green_i      = '0;
  logic [7:0]  blue_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        led_line_o;
  logic        serializer_busy_o;
  logic [2:0]  shown_mode_o;
  logic        segment_index_o;

  led_pattern_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned words_total = 0;
  int unsigned settings_n = 0;

  status_led_pattern_serializer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .mode_value_i      (mode_value_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .led_line_o        (led_line_o),
    .serializer_busy_o (serializer_busy_o),
    .shown_mode_o      (shown_mode_o),
    .segment_index_o   (segment_index_o)
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(led_line_o, serializer_busy_o, shown_mode_o, segment_index_o);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // offer one input word and hold it until taken
  task automatic send_word(logic [1:0] cmd, logic [2:0] mode,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    mode_value_i <= mode;
    red_i        <= r;
    green_i      <= g;
    blue_i       <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(cmd, mode, r, g, b);
  endtask

  // random word, tick heavy so patterns advance; ignored words are flagged
  task automatic random_word(output bit counts);
    int unsigned roll;
    logic [1:0]  cmd;
    logic [2:0]  mode;
    logic [7:0]  r, g, b;
    roll = $urandom_range(0, 99);
    mode = 3'($urandom_range(0, 7));
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    if (roll < 88) begin
      cmd = CMD_TICK;
    end else if (roll < 93) begin
      cmd = CMD_MODE;
      if ($urandom_range(0, 7) == 0)
        mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
      else if ($urandom_range(0, 1) != 0)
        mode = $urandom_range(0, 1) ? MODE_ACTIVE_TX : MODE_ERROR;
      else
        mode = 3'($urandom_range(MODE_INIT, MODE_ERROR));
    end else if (roll < 98) begin
      cmd = CMD_COLOR;
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    end else begin
      cmd = CMD_RSVD;
    end
    counts = !(cmd == CMD_RSVD || (cmd == CMD_MODE && mode > MODE_ERROR));
    send_word(cmd, mode, r, g, b);
  endtask

  // let every expected word come back, then give the pipeline time to drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // one register write; write enable stays high across back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // narrow registers get junk in the upper byte
  task automatic apply_settings(logic [7:0] zero_hi, logic [7:0] one_hi, logic [7:0] bit_len,
                                logic [15:0] gap_len, logic [15:0] ms_ticks);
    write_reg(REG_ZERO_HIGH, {8'($urandom_range(0, 255)), zero_hi});
    write_reg(REG_ONE_HIGH, {8'($urandom_range(0, 255)), one_hi});
    write_reg(REG_BIT_PERIOD, {8'($urandom_range(0, 255)), bit_len});
    write_reg(REG_LATCH_GAP, gap_len);
    write_reg(REG_TICKS_MS, ms_ticks);
    cfg_we_i <= 1'b0;
    settings_n++;
  endtask

  task automatic run_phase(logic [7:0] zero_hi, logic [7:0] one_hi, logic [7:0] bit_len,
                           logic [15:0] gap_len, logic [15:0] ms_ticks,
                           int unsigned words, bit quiet);
    int unsigned n;
    bit          counts;
    n = 0;
    settle();
    apply_settings(zero_hi, one_hi, bit_len, gap_len, ms_ticks);
    calm = quiet;
    while (n < words) begin
      random_word(counts);
      if (counts) n++;
    end
    words_total += n;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: pattern start, pixel replacement, every mode, ignored words
    send_word(CMD_TICK, MODE_INIT, 8'h00, 8'h00, 8'h00);
    send_word(CMD_COLOR, MODE_RSVD_HI, 8'hff, 8'hff, 8'hff);
    send_word(CMD_COLOR, MODE_INIT, 8'h00, 8'h00, 8'h00);
    send_word(CMD_TICK, MODE_RSVD_HI, 8'hff, 8'hff, 8'hff);
    send_word(CMD_RSVD, MODE_RSVD_HI, 8'hff, 8'hff, 8'hff);
    send_word(CMD_MODE, MODE_RSVD_HI, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_RSVD_LO, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_INIT, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_CONNECTING, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_OK, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_WATERING, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_ERROR, 8'h00, 8'h00, 8'h00);
    send_word(CMD_MODE, MODE_ACTIVE_TX, 8'h00, 8'h00, 8'h00);
    send_word(CMD_TICK, MODE_OK, 8'h55, 8'haa, 8'h0f);
    send_word(CMD_COLOR, MODE_OK, 8'haa, 8'h55, 8'hf0);
    send_word(CMD_TICK, MODE_OK, 8'h00, 8'h00, 8'h00);
    send_word(CMD_RSVD, MODE_INIT, 8'h00, 8'h00, 8'h00);
    repeat (5) send_word(CMD_TICK, MODE_INIT, 8'h00, 8'h00, 8'h00);
    words_total += 22;

    // random phases, extremes and the degenerate timings among them
    run_phase(8'd1, 8'd2, 8'd3, 16'd4, 16'd1, 160, 1'b0);
    run_phase(8'd255, 8'd255, 8'd0, 16'd0, 16'd0, 140, 1'b0);
    run_phase(8'd2, 8'd5, 8'd1, 16'd1, 16'd1, 110, 1'b0);
    run_phase(8'd255, 8'd1, 8'd255, 16'd65535, 16'd65535, 70, 1'b0);
    run_phase(8'd3, 8'd6, 8'd8, 16'd10, 16'd1, 140, 1'b1);
    run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), 8'($urandom_range(2, 10)),
              16'($urandom_range(1, 30)), 16'd1, 160, 1'b0);
    run_phase(ZERO_HIGH_RST, ONE_HIGH_RST, BIT_PERIOD_RST, LATCH_GAP_RST, TICKS_MS_RST,
              40, 1'b0);
    settle();

    $display("covered %0d input words under %0d register settings, %0d result words checked",
             words_total, settings_n + 1, sb.checked);
    $display("modes that played (bit per mode): %b", sb.modes_seen);
    if (sb.errors == 0 && sb.waiting() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
